>>> hdl/grd_pkg.sv
// ---------------------------------------------------------------------------
// grd_pkg: shared types and constants for the graph reachability block
// Vertex and count widths, item kind codes, memory request records and the
// lowest-set-bit helper used by the walk controller.
// ---------------------------------------------------------------------------
package grd_pkg;

  localparam int NUM_VERTICES = 16;
  localparam int VTX_W        = 4;   // vertex index width
  localparam int CNT_W        = 5;   // vertex_count register width
  localparam int FUNC_W       = 2;

  // item kinds carried on the input tuser
  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_QUERY  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef logic [NUM_VERTICES-1:0] row_t;
  typedef logic [VTX_W-1:0]        vtx_t;

  // single-port memory request: write enable, address, write data
  typedef struct packed {
    logic we;
    vtx_t addr;
    row_t wdata;
  } adj_req_t;

  typedef struct packed {
    logic we;
    vtx_t addr;
    vtx_t wdata;
  } stk_req_t;

  // index of the lowest set bit (0 when the mask is empty)
  function automatic vtx_t lowest_idx(input row_t mask);
    vtx_t idx;
    idx = '0;
    for (int i = NUM_VERTICES - 1; i >= 0; i--) begin
      if (mask[i]) begin
        idx = VTX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

>>> hdl/graph_reachability_dfs.sv
// ---------------------------------------------------------------------------
// graph_reachability_dfs: directed graph reachability over an adjacency RAM
// Clears edges, inserts directed edges and answers reachable-set queries by a
// depth-first walk with an explicit stack held in a second RAM.
//
//   channel   dir  handshake            payload
//   s_axis    in   s_tvalid/s_tready    tdata: from_vertex, to_vertex; tuser: func
//   m_axis    out  m_tvalid/m_tready    tdata: reachable_mask; tuser: bad_vertex
//   cfg       in   cfg_valid/cfg_ready  cfg_data: vertex_count
//
// Clear empties all rows; insert reads, then writes back the tail's adjacency
// row, and is skipped when an end is out of range. A query pops a vertex from
// the single-port stack RAM, reads its row of the single-port adjacency RAM and
// pushes each unvisited neighbour until the stack is empty; a source out of range skips the walk.
// Reset clears all edges at once through per-row valid bits, no sweep.
// One item is worked at a time; a finished result sits in the output register
// while the next item is taken in, and waits in the done state while it is full.
// ---------------------------------------------------------------------------
module graph_reachability_dfs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [7:0]                s_tdata,   // [3:0] from_vertex, [7:4] to_vertex
  input  logic [1:0]                s_tuser,   // [1:0] func
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [15:0]               m_tdata,   // [15:0] reachable_mask
  output logic                      m_tuser,   // [0] bad_vertex
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [grd_pkg::CNT_W-1:0] cfg_data
);
  import grd_pkg::*;

  logic [CNT_W-1:0] vertex_count;
  adj_req_t         adj_req;
  row_t             adj_rdata;
  stk_req_t         stk_req;
  vtx_t             stk_rdata;
  logic             res_valid;
  logic             res_ready;
  row_t             res_mask;
  logic             res_bad;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= CNT_W'(NUM_VERTICES);
    end else if (cfg_valid) begin
      vertex_count <= cfg_data;
    end
  end

  grd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_func      (s_tuser),
    .in_from      (s_tdata[3:0]),
    .in_to        (s_tdata[7:4]),
    .vertex_count (vertex_count),
    .adj_req      (adj_req),
    .adj_rdata    (adj_rdata),
    .stk_req      (stk_req),
    .stk_rdata    (stk_rdata),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res_mask     (res_mask),
    .res_bad      (res_bad)
  );

  // adjacency rows, one per tail vertex
  grd_ram #(
    .WIDTH (NUM_VERTICES),
    .DEPTH (NUM_VERTICES)
  ) u_adj_ram (
    .clk   (clk),
    .we    (adj_req.we),
    .addr  (adj_req.addr),
    .wdata (adj_req.wdata),
    .rdata (adj_rdata)
  );

  // walk stack
  grd_ram #(
    .WIDTH (VTX_W),
    .DEPTH (NUM_VERTICES)
  ) u_stk_ram (
    .clk   (clk),
    .we    (stk_req.we),
    .addr  (stk_req.addr),
    .wdata (stk_req.wdata),
    .rdata (stk_rdata)
  );

  // output register
  assign res_ready = !m_tvalid || m_tready;
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= res_mask;
      m_tuser <= res_bad;
    end
  end

endmodule

>>> hdl/grd_ram.sv
// ---------------------------------------------------------------------------
// grd_ram: generic single-port synchronous RAM
// One access per cycle, write and read at the same address, read data
// registered.
// ---------------------------------------------------------------------------
module grd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> hdl/grd_ctrl.sv
// ---------------------------------------------------------------------------
// grd_ctrl: item sequencer and depth-first walk engine
// Runs clear, edge insert (read-modify-write of one adjacency row) and the
// reachability walk over the adjacency and stack memories.
// ---------------------------------------------------------------------------
module grd_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  // input items
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [grd_pkg::FUNC_W-1:0] in_func,
  input  logic [grd_pkg::VTX_W-1:0]  in_from,
  input  logic [grd_pkg::VTX_W-1:0]  in_to,
  // configuration
  input  logic [grd_pkg::CNT_W-1:0]  vertex_count,
  // adjacency memory
  output grd_pkg::adj_req_t          adj_req,
  input  grd_pkg::row_t              adj_rdata,
  // walk stack memory
  output grd_pkg::stk_req_t          stk_req,
  input  grd_pkg::vtx_t              stk_rdata,
  // results
  output logic                       res_valid,
  input  logic                       res_ready,
  output grd_pkg::row_t              res_mask,
  output logic                       res_bad
);
  import grd_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_INS_RD = 8'b0000_0010,
    S_INS_WR = 8'b0000_0100,
    S_POP    = 8'b0000_1000,
    S_STK    = 8'b0001_0000,
    S_ROW    = 8'b0010_0000,
    S_PUSH   = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t            state, state_next;
  vtx_t              src;        // insert tail
  vtx_t              dst;        // insert head
  row_t              visited;
  row_t              fresh;      // neighbors still to push
  logic [CNT_W-1:0]  depth;      // stack fill, 0..NUM_VERTICES-1
  row_t              row_vld;    // adjacency row holds written data
  logic              rd_vld;     // valid bit of the row being read
  logic              bad;

  logic [CNT_W-1:0]  cnt_eff;
  row_t              live;
  row_t              row_eff;
  logic              accept;
  logic              from_ok;
  logic              to_ok;
  logic [CNT_W-1:0]  depth_dec;
  vtx_t              push_idx;
  row_t              push_bit;

  // effective vertex count and mask of vertices in use
  always_comb begin
    cnt_eff = (vertex_count > CNT_W'(NUM_VERTICES)) ? CNT_W'(NUM_VERTICES) : vertex_count;
    for (int i = 0; i < NUM_VERTICES; i++) begin
      live[i] = (CNT_W'(i) < cnt_eff);
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign from_ok   = ({1'b0, in_from} < cnt_eff);
  assign to_ok     = ({1'b0, in_to} < cnt_eff);
  assign row_eff   = rd_vld ? adj_rdata : '0;
  assign depth_dec = depth - CNT_W'(1);
  assign push_idx  = lowest_idx(fresh);
  assign push_bit  = row_t'(1) << push_idx;

  assign res_valid = (state == S_DONE);
  assign res_mask  = visited;
  assign res_bad   = bad;

  // memory requests
  always_comb begin
    adj_req = '0;
    stk_req = '0;
    unique case (state)
      S_IDLE: begin
        // first push of the source
        stk_req.we    = accept && (func_t'(in_func) == FUNC_QUERY) && from_ok;
        stk_req.addr  = '0;
        stk_req.wdata = in_from;
      end
      S_INS_RD: begin
        adj_req.addr = src;
      end
      S_INS_WR: begin
        adj_req.we    = 1'b1;
        adj_req.addr  = src;
        adj_req.wdata = row_eff | (row_t'(1) << dst);
      end
      S_POP: begin
        stk_req.addr = depth_dec[VTX_W-1:0];
      end
      S_STK: begin
        adj_req.addr = stk_rdata;
      end
      S_ROW: begin
      end
      S_PUSH: begin
        stk_req.we    = (fresh != '0);
        stk_req.addr  = depth[VTX_W-1:0];
        stk_req.wdata = push_idx;
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (func_t'(in_func))
            FUNC_INSERT: if (from_ok && to_ok) state_next = S_INS_RD;
            FUNC_QUERY:  state_next = from_ok ? S_POP : S_DONE;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_INS_RD: state_next = S_INS_WR;
      S_INS_WR: state_next = S_IDLE;
      S_POP:    state_next = (depth == '0) ? S_DONE : S_STK;
      S_STK:    state_next = S_ROW;
      S_ROW:    state_next = S_PUSH;
      S_PUSH:   state_next = (fresh == '0) ? S_POP : S_PUSH;
      S_DONE:   if (res_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      row_vld <= '0;
      depth   <= '0;
      visited <= '0;
      bad     <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (func_t'(in_func))
              FUNC_CLEAR: row_vld <= '0;
              FUNC_QUERY: begin
                bad     <= !from_ok;
                visited <= from_ok ? (row_t'(1) << in_from) : '0;
                depth   <= from_ok ? CNT_W'(1) : '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_INS_WR: row_vld[src] <= 1'b1;
        S_POP:    if (depth != '0) depth <= depth_dec;
        S_PUSH: begin
          if (fresh != '0) begin
            depth   <= depth + CNT_W'(1);
            visited <= visited | push_bit;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      src <= in_from;
      dst <= in_to;
    end
    if (state == S_INS_RD) begin
      rd_vld <= row_vld[src];
    end else if (state == S_STK) begin
      rd_vld <= row_vld[stk_rdata];
    end
    if (state == S_ROW) begin
      fresh <= row_eff & live & ~visited;
    end else if (state == S_PUSH) begin
      fresh <= fresh & ~push_bit;
    end
  end

endmodule
